// ===== rtl/remove_k_nearest_values_defines.svh =====
// Assertion helpers shared by the RTL of the nearest-value removal block.
// Both sample on the rising edge of clk and are off while rst_n is low.
`ifndef REMOVE_K_NEAREST_VALUES_DEFINES_SVH
`define REMOVE_K_NEAREST_VALUES_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RKNV_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RKNV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/rknv_pkg.sv =====
package rknv_pkg;

  // Field widths fixed by the item formats.
  localparam int VALUE_W  = 32;
  localparam int DIST_W   = VALUE_W + 1;
  localparam int RMCNT_W  = 7;

  localparam logic [RMCNT_W-1:0] RMCNT_RESET = 7'd5;

  // Input item modes.
  localparam logic MODE_APPEND = 1'b0;
  localparam logic MODE_QUERY  = 1'b1;

  typedef struct packed {
    logic                      mode;
    logic signed [VALUE_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] element;
    logic                      last;
    logic                      empty_res;
    logic                      overflowed;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RM_CHK,
    ST_RM_SCAN,
    ST_RM_MARK,
    ST_EMIT_RD,
    ST_EMIT_WR,
    ST_EMIT_EMPTY,
    ST_DONE
  } state_t;

endpackage

// ===== rtl/remove_k_nearest_values.sv =====
// Nearest-value removal store.
// The input channel (in_valid/in_ready/in_data) carries two kinds of item.
// An append item writes its value at the end of the store; while the block
// is idle appends are taken back to back, one per cycle. A full store drops
// further appends and sets a sticky overflow flag.
// A query item holds in_ready low until the query has finished. The block
// removes, at most remove_count times, the live entry nearest to the target
// (lowest index on a tie). Each removal is one pass of the store's single
// read port over all appended entries. Removed entries are only masked,
// so the remaining ones keep their order.
// The remaining entries then leave on out_valid/out_ready in store order,
// masked entries skipped, the final one with last set; an empty store
// yields a single item with empty_res set.
// A registered output stage lets the receiver stall at will: the block waits
// with the next item until the stage is free. After the run, once the read
// pointer has passed any masked entries behind the last item, the store,
// the overflow flag and the mask are cleared. cfg_we/cfg_wdata set
// remove_count; the user must write it only while idle (not enforced here).
// Reset empties the store, clears the overflow flag, sets remove_count to 5.
module remove_k_nearest_values
  import rknv_pkg::*;
#(
  parameter int STORE_DEPTH = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  in_item_t            in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output out_item_t           out_data,
  input  logic                cfg_we,
  input  logic [RMCNT_W-1:0]  cfg_wdata
);

`include "remove_k_nearest_values_defines.svh"

  localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int CW = $clog2(STORE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(STORE_DEPTH);

  // Store memory and its registered read data.
  logic signed [VALUE_W-1:0] mem [STORE_DEPTH];
  logic signed [VALUE_W-1:0] rd_q_r;

  state_t                    state_r, state_nxt;
  logic [CW-1:0]             count_r;
  logic [CW-1:0]             live_r;
  logic                      ovf_r;
  logic [STORE_DEPTH-1:0]    removed_r;
  logic [RMCNT_W-1:0]        rmcnt_r;
  logic [RMCNT_W-1:0]        rem_left_r;
  logic signed [VALUE_W-1:0] target_r;
  logic [CW-1:0]             addr_r;
  logic [CW-1:0]             emit_cnt_r;
  logic                      p1_vld_r;
  logic [AW-1:0]             p1_idx_r;
  logic                      p2_vld_r;
  logic [AW-1:0]             p2_idx_r;
  logic [DIST_W-1:0]         p2_dist_r;
  logic                      best_vld_r;
  logic [AW-1:0]             best_idx_r;
  logic [DIST_W-1:0]         best_dist_r;
  logic                      out_valid_r;
  out_item_t                 out_data_r;

  logic                      append, q_start, scan_start, scan_rd, mem_re;
  logic                      addr_clr, addr_inc, mark, emit_load, empty_load, clear_all;
  logic                      out_free;
  logic [AW-1:0]             addr_idx;
  logic [DIST_W-1:0]         diff;
  logic [DIST_W-1:0]         abs_dist;

  assign addr_idx  = addr_r[AW-1:0];
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Sequencer: next state and control strobes.
  always_comb begin
    state_nxt  = state_r;
    in_ready   = 1'b0;
    append     = 1'b0;
    q_start    = 1'b0;
    scan_start = 1'b0;
    scan_rd    = 1'b0;
    mem_re     = 1'b0;
    addr_clr   = 1'b0;
    addr_inc   = 1'b0;
    mark       = 1'b0;
    emit_load  = 1'b0;
    empty_load = 1'b0;
    clear_all  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_data.mode == MODE_QUERY) begin
            q_start   = 1'b1;
            state_nxt = ST_RM_CHK;
          end else begin
            append = 1'b1;
          end
        end
      end
      ST_RM_CHK: begin
        addr_clr = 1'b1;
        if (rem_left_r == '0 || live_r == '0) begin
          state_nxt = (live_r == '0) ? ST_EMIT_EMPTY : ST_EMIT_RD;
        end else begin
          scan_start = 1'b1;
          state_nxt  = ST_RM_SCAN;
        end
      end
      ST_RM_SCAN: begin
        if (addr_r != count_r) begin
          scan_rd  = 1'b1;
          mem_re   = 1'b1;
          addr_inc = 1'b1;
        end else if (!p1_vld_r && !p2_vld_r) begin
          state_nxt = ST_RM_MARK;
        end
      end
      ST_RM_MARK: begin
        mark      = 1'b1;
        state_nxt = ST_RM_CHK;
      end
      ST_EMIT_RD: begin
        priority if (addr_r == count_r) begin
          state_nxt = ST_DONE;
        end else if (removed_r[addr_idx]) begin
          addr_inc = 1'b1;
        end else begin
          mem_re    = 1'b1;
          state_nxt = ST_EMIT_WR;
        end
      end
      ST_EMIT_WR: begin
        if (out_free) begin
          emit_load = 1'b1;
          addr_inc  = 1'b1;
          state_nxt = ST_EMIT_RD;
        end
      end
      ST_EMIT_EMPTY: begin
        if (out_free) begin
          empty_load = 1'b1;
          state_nxt  = ST_DONE;
        end
      end
      ST_DONE: begin
        clear_all = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Store memory: appends write at the fill point, scans and emission read.
  always_ff @(posedge clk) begin
    if (append && count_r != DEPTH_C) begin
      mem[count_r[AW-1:0]] <= in_data.value;
    end
    if (mem_re) begin
      rd_q_r <= mem[addr_idx];
    end
  end

  // Absolute distance at full precision, one bit wider than the values.
  assign diff     = {rd_q_r[VALUE_W-1], rd_q_r} - {target_r[VALUE_W-1], target_r};
  assign abs_dist = diff[DIST_W-1] ? (~diff + DIST_W'(1)) : diff;

  // Fill count, overflow flag, removal mask and query bookkeeping.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      live_r     <= '0;
      ovf_r      <= 1'b0;
      removed_r  <= '0;
      rmcnt_r    <= RMCNT_RESET;
      rem_left_r <= '0;
    end else begin
      if (cfg_we) begin
        rmcnt_r <= cfg_wdata;
      end
      if (append) begin
        if (count_r != DEPTH_C) begin
          count_r <= count_r + CW'(1);
        end else begin
          ovf_r <= 1'b1;
        end
      end
      if (q_start) begin
        live_r     <= count_r;
        rem_left_r <= rmcnt_r;
      end
      if (mark) begin
        removed_r[best_idx_r] <= 1'b1;
        live_r                <= live_r - CW'(1);
        rem_left_r            <= rem_left_r - RMCNT_W'(1);
      end
      if (clear_all) begin
        count_r   <= '0;
        ovf_r     <= 1'b0;
        removed_r <= '0;
      end
    end
  end

  // Query target and the shared address counter.
  always_ff @(posedge clk) begin
    if (q_start) begin
      target_r <= in_data.value;
    end
    if (addr_clr) begin
      addr_r     <= '0;
      emit_cnt_r <= '0;
    end else begin
      if (addr_inc) begin
        addr_r <= addr_r + CW'(1);
      end
      if (emit_load) begin
        emit_cnt_r <= emit_cnt_r + CW'(1);
      end
    end
  end

  // Scan pipeline: read, distance, then compare against the best so far.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r   <= 1'b0;
      p2_vld_r   <= 1'b0;
      best_vld_r <= 1'b0;
    end else begin
      p1_vld_r <= scan_rd;
      p2_vld_r <= p1_vld_r && !removed_r[p1_idx_r];
      if (scan_start) begin
        best_vld_r <= 1'b0;
      end else if (p2_vld_r && (!best_vld_r || p2_dist_r < best_dist_r)) begin
        best_vld_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    p1_idx_r  <= addr_idx;
    p2_idx_r  <= p1_idx_r;
    p2_dist_r <= abs_dist;
    if (!scan_start && p2_vld_r && (!best_vld_r || p2_dist_r < best_dist_r)) begin
      best_idx_r  <= p2_idx_r;
      best_dist_r <= p2_dist_r;
    end
  end

  // Output stage: holds one item until the receiver takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_load || empty_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      out_data_r.element    <= rd_q_r;
      out_data_r.last       <= ((emit_cnt_r + CW'(1)) == live_r);
      out_data_r.empty_res  <= 1'b0;
      out_data_r.overflowed <= ovf_r;
    end else if (empty_load) begin
      out_data_r.element    <= '0;
      out_data_r.last       <= 1'b1;
      out_data_r.empty_res  <= 1'b1;
      out_data_r.overflowed <= ovf_r;
    end
  end

  // Outside idle the live count never exceeds the fill count; the fill count never exceeds the depth.
  `RKNV_ASSERT_NOW(a_count_bound, 1'b1, (live_r <= count_r || state_r == ST_IDLE) && count_r <= DEPTH_C, "count out of range")
  // A removal always targets a stored entry that is still live.
  `RKNV_ASSERT_NOW(a_mark_live, state_r == ST_RM_MARK, best_vld_r && !removed_r[best_idx_r] && CW'(best_idx_r) < count_r, "removal of a dead entry")
  // An accepted query starts the removal sequence.
  `RKNV_ASSERT_NEXT(a_query_start, in_valid && in_ready && in_data.mode == MODE_QUERY, state_r == ST_RM_CHK && !in_ready, "query not started")
  // An empty result is always the final item of its run.
  `RKNV_ASSERT_NOW(a_empty_last, out_valid && out_data.empty_res, out_data.last, "empty result without last")

endmodule

// ===== tb/remove_k_nearest_values_test.sv =====
`timescale 1ns / 100ps

module remove_k_nearest_values_test;
  import rknv_pkg::*;

  localparam int DEPTH = 64;
  localparam int QUIET_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 8;
  localparam int ITEMS_PER_PHASE = 64;

  // Expected behavior of the store, kept in step with every accepted item.
  class nearest_store_scoreboard;
    logic signed [VALUE_W-1:0] kept[$];
    logic overflow_seen;
    int unsigned removals_per_query;
    out_item_t expected_results[$];
    int mismatches;
    int results_checked;
    int queries_seen;
    int appends_dropped;

    function new();
      overflow_seen = 1'b0;
      removals_per_query = RMCNT_RESET;
      mismatches = 0;
      results_checked = 0;
      queries_seen = 0;
      appends_dropped = 0;
    endfunction

    function void set_removals(int unsigned count);
      removals_per_query = count;
    endfunction

    function bit idle();
      return expected_results.size() == 0;
    endfunction

    // Apply one accepted input item and queue the results it causes.
    function void note_input(in_item_t item);
      int unsigned removed;
      int best;
      longint best_dist;
      longint gap_mag;
      out_item_t res;
      if (item.mode == MODE_APPEND) begin
        if (kept.size() < DEPTH) begin
          kept.push_back(item.value);
        end else begin
          overflow_seen = 1'b1;
          appends_dropped++;
        end
        return;
      end
      queries_seen++;
      // Remove the nearest element, lowest index on a tie, until the count runs out.
      for (removed = 0; removed < removals_per_query && kept.size() > 0; removed++) begin
        best = 0;
        best_dist = 0;
        for (int i = 0; i < kept.size(); i++) begin
          gap_mag = longint'(kept[i]) - longint'(item.value);
          if (gap_mag < 0) begin
            gap_mag = -gap_mag;
          end
          if (i == 0 || gap_mag < best_dist) begin
            best_dist = gap_mag;
            best = i;
          end
        end
        kept.delete(best);
      end
      // Emit what is left, or one empty marker.
      if (kept.size() == 0) begin
        res.element = '0;
        res.last = 1'b1;
        res.empty_res = 1'b1;
        res.overflowed = overflow_seen;
        expected_results.push_back(res);
      end else begin
        for (int i = 0; i < kept.size(); i++) begin
          res.element = kept[i];
          res.last = (i == kept.size() - 1);
          res.empty_res = 1'b0;
          res.overflowed = overflow_seen;
          expected_results.push_back(res);
        end
      end
      kept.delete();
      overflow_seen = 1'b0;
    endfunction

    // Compare one accepted result against the oldest expectation.
    function void check_result(out_item_t got);
      out_item_t want;
      results_checked++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Unexpected result: element=%0d last=%b empty_res=%b overflowed=%b",
                   got.element, got.last, got.empty_res, got.overflowed);
        end
        return;
      end
      want = expected_results.pop_front();
      if (got.element !== want.element || got.last !== want.last ||
          got.empty_res !== want.empty_res || got.overflowed !== want.overflowed) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Mismatch on result %0d: expected element=%0d last=%b empty_res=%b %s%b",
                   results_checked, want.element, want.last, want.empty_res,
                   "overflowed=", want.overflowed);
          $display("  actual element=%0d last=%b empty_res=%b overflowed=%b",
                   got.element, got.last, got.empty_res, got.overflowed);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [RMCNT_W-1:0] cfg_wdata = '0;

  nearest_store_scoreboard book;
  int quiet_cycles = 0;
  int items_sent = 0;
  int stall_left = 0;
  int cycle_count = 0;
  bit calm = 1'b0;

  remove_k_nearest_values #(
    .STORE_DEPTH(DEPTH)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #6 clk = ~clk;

  // Gap length for either side: mostly none or short, now and then long.
  function automatic int pick_gap();
    int roll;
    if (calm) begin
      return 0;
    end
    roll = $urandom_range(99);
    if (roll < 55) begin
      return 0;
    end
    if (roll < 85) begin
      return $urandom_range(3, 1);
    end
    if (roll < 97) begin
      return $urandom_range(10, 4);
    end
    return $urandom_range(60, 20);
  endfunction

  // Values lean toward extremes and a narrow band so that ties happen.
  function automatic logic signed [VALUE_W-1:0] pick_value();
    logic signed [VALUE_W-1:0] v;
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(3))
          0: v = 32'h7fffffff;
          1: v = 32'h80000000;
          2: v = '0;
          default: v = '1;
        endcase
      end
      1, 2, 3: begin
        v = $urandom_range(40);
        v = v - 20;
      end
      default: v = $urandom();
    endcase
    return v;
  endfunction

  // Every so often switch between stretches with and without idling.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count % 256 == 0) begin
      calm = ($urandom_range(3) == 0);
    end
  end

  // The receiver stalls at random.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
      stall_left = pick_gap();
    end
  end

  // Watch both channels: predict on every input item, check every result.
  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else begin
      if (in_valid && in_ready) begin
        book.note_input(in_data);
      end
      if (out_valid && out_ready) begin
        book.check_result(out_data);
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Give up when nothing has moved for far longer than the slowest query takes.
  initial begin
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
    end
    $display("Timeout: no item moved for %0d cycles", QUIET_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  // Offer one item and hold it until it is taken.
  task automatic send_item(input logic mode, input logic signed [VALUE_W-1:0] value);
    int gap;
    in_item_t item;
    gap = pick_gap();
    item.mode = mode;
    item.value = value;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    items_sent++;
  endtask

  // Stop sending and wait for every expected result.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (!book.idle()) begin
      @(posedge clk);
    end
  endtask

  // Change the removal count once the block has gone idle.
  task automatic write_removals(input int unsigned count);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    // The block may still be stepping over masked entries after the last result.
    while (!in_ready) begin
      @(posedge clk);
    end
    cfg_we <= 1'b1;
    cfg_wdata <= count[RMCNT_W-1:0];
    @(posedge clk);
    book.set_removals(count);
    cfg_we <= 1'b0;
  endtask

  // Random fill-then-query sequences; a burst can be forced to overrun the store.
  task automatic run_sequences(input int budget, input bit force_burst);
    int sent;
    int fill;
    int roll;
    bit first;
    sent = 0;
    first = 1'b1;
    while (sent < budget) begin
      roll = $urandom_range(99);
      if (force_burst && first) begin
        fill = $urandom_range(68, 65);
      end else if (roll < 10) begin
        fill = $urandom_range(68, 60);
      end else if (roll < 18) begin
        fill = 0;
      end else begin
        fill = $urandom_range(12, 1);
      end
      for (int i = 0; i < fill; i++) begin
        send_item(MODE_APPEND, pick_value());
      end
      if ($urandom_range(9) == 0) begin
        drain_results();
      end
      send_item(MODE_QUERY, pick_value());
      sent += fill + 1;
      first = 1'b0;
    end
  endtask

  initial begin
    book = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset count of five: a query on an empty store first.
    send_item(MODE_QUERY, 32'sd0);
    // Extreme values; the target at the negative limit must not wrap.
    send_item(MODE_APPEND, 32'h7fffffff);
    send_item(MODE_APPEND, 32'h80000000);
    send_item(MODE_APPEND, 32'sd0);
    send_item(MODE_APPEND, -32'sd1);
    send_item(MODE_APPEND, 32'sd1);
    send_item(MODE_APPEND, 32'sd7);
    send_item(MODE_APPEND, 32'sd7);
    send_item(MODE_APPEND, -32'sd100);
    send_item(MODE_QUERY, 32'h80000000);
    // Fewer elements than removals: the store empties before the count runs out.
    send_item(MODE_APPEND, 32'sd5);
    send_item(MODE_APPEND, -32'sd5);
    send_item(MODE_APPEND, 32'sd0);
    send_item(MODE_QUERY, 32'h7fffffff);

    // One removal with all distances equal: the first element goes.
    write_removals(1);
    send_item(MODE_APPEND, 32'sd20);
    send_item(MODE_APPEND, 32'sd10);
    send_item(MODE_APPEND, 32'sd20);
    send_item(MODE_QUERY, 32'sd15);

    // Random phases over a range of removal counts, extremes included.
    write_removals(0);
    run_sequences(ITEMS_PER_PHASE, 1'b1);
    write_removals(127);
    run_sequences(ITEMS_PER_PHASE, 1'b0);
    write_removals(64);
    run_sequences(ITEMS_PER_PHASE, 1'b1);
    write_removals(3);
    run_sequences(ITEMS_PER_PHASE, 1'b1);
    write_removals($urandom_range(9, 2));
    run_sequences(ITEMS_PER_PHASE, 1'b0);

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (!book.idle()) begin
      book.mismatches += book.expected_results.size();
      $display("%0d expected results never arrived", book.expected_results.size());
    end

    $display("Ran %0d items with %0d queries and %0d appends dropped on a full store.",
             items_sent, book.queries_seen, book.appends_dropped);
    $display("Checked %0d results, %0d mismatches.", book.results_checked, book.mismatches);
    if (book.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
